[hw/rtl/ptt_pkg.sv]
// Shared types, codes and helpers for the partition text tokenizer.
// Used by ptt_lexer, ptt_out_fifo and partition_text_tokenizer_top.
`timescale 1ns / 1ps

package ptt_pkg;

  // Widths of the internal run length and stream offset counters.
  localparam int LENGTH_BITS = 16;
  localparam int OFFSET_BITS = 32;

  // Depth of the result queue; it must hold two results beyond a full stall.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // Token classes. Punctuation byte classes share these codes.
  localparam logic [3:0] TK_SLASH = 4'd0;
  localparam logic [3:0] TK_DASH  = 4'd1;
  localparam logic [3:0] TK_EQUAL = 4'd2;
  localparam logic [3:0] TK_SEMI  = 4'd3;
  localparam logic [3:0] TK_COMMA = 4'd4;
  localparam logic [3:0] TK_COLON = 4'd5;
  localparam logic [3:0] TK_OPAR  = 4'd6;
  localparam logic [3:0] TK_CPAR  = 4'd7;
  localparam logic [3:0] TK_WS    = 4'd8;
  localparam logic [3:0] TK_NUM   = 4'd9;
  localparam logic [3:0] TK_FLT   = 4'd10;
  localparam logic [3:0] TK_STR   = 4'd11;
  localparam logic [3:0] TK_NL    = 4'd12;
  localparam logic [3:0] TK_UNK   = 4'd13;
  localparam logic [3:0] TK_EOF   = 4'd14;

  // Byte classes beyond the punctuation codes.
  localparam logic [3:0] BC_SPACE = 4'd8;
  localparam logic [3:0] BC_NL    = 4'd9;
  localparam logic [3:0] BC_DIGIT = 4'd10;
  localparam logic [3:0] BC_CHAR  = 4'd11;
  localparam logic [3:0] BC_DOT   = 4'd12;
  localparam logic [3:0] BC_UNK   = 4'd13;

  // Lexer modes.
  localparam logic [2:0] M_IDLE  = 3'd0;
  localparam logic [2:0] M_WS    = 3'd1;
  localparam logic [2:0] M_INT   = 3'd2;
  localparam logic [2:0] M_FLOAT = 3'd3;
  localparam logic [2:0] M_NSTR  = 3'd4;
  localparam logic [2:0] M_STR   = 3'd5;
  localparam logic [2:0] M_NL    = 3'd6;

  // One result item as it leaves the block.
  typedef struct packed {
    logic [3:0]  token_class;
    logic [15:0] token_length;
    logic [31:0] token_offset;
    logic        last_result;
  } token_t;

  // Up to two results caused by one input item, in order.
  typedef struct packed {
    logic [1:0] count;
    token_t     first;
    token_t     second;
  } token_pair_t;

  // Fixed ASCII class table.
  function automatic logic [3:0] byte_class(logic [7:0] b);
    logic [3:0] c;
    c = BC_UNK;
    if (b >= "0" && b <= "9") begin
      c = BC_DIGIT;
    end else if ((b >= "A" && b <= "Z") || (b >= "a" && b <= "z")) begin
      c = BC_CHAR;
    end else begin
      unique case (b)
        "?", "_", "|": c = BC_CHAR;
        " ", 8'd9:     c = BC_SPACE;
        8'd10, 8'd13:  c = BC_NL;
        ".":           c = BC_DOT;
        "/":           c = TK_SLASH;
        "-":           c = TK_DASH;
        "=":           c = TK_EQUAL;
        ";":           c = TK_SEMI;
        ",":           c = TK_COMMA;
        ":":           c = TK_COLON;
        "(":           c = TK_OPAR;
        ")":           c = TK_CPAR;
        default:       c = BC_UNK;
      endcase
    end
    return c;
  endfunction

  // Token class reported for a pending run in a given mode.
  function automatic logic [3:0] mode_token(logic [2:0] m);
    logic [3:0] t;
    unique case (m)
      M_WS:           t = TK_WS;
      M_INT:          t = TK_NUM;
      M_FLOAT:        t = TK_FLT;
      M_NSTR, M_STR:  t = TK_STR;
      default:        t = TK_NL;
    endcase
    return t;
  endfunction

  // Mode after byte class c when it continues mode m, else idle.
  function automatic logic [2:0] continue_mode(logic [2:0] m, logic [3:0] c);
    logic [2:0] n;
    n = M_IDLE;
    unique case (m)
      M_WS: begin
        if (c == BC_SPACE) n = M_WS;
      end
      M_INT: begin
        if (c == BC_DIGIT)     n = M_INT;
        else if (c == BC_DOT)  n = M_FLOAT;
        else if (c == BC_CHAR) n = M_NSTR;
      end
      M_FLOAT: begin
        if (c == BC_DIGIT)     n = M_FLOAT;
        else if (c == BC_CHAR) n = M_NSTR;
      end
      M_NSTR: begin
        if (c == BC_CHAR || c == BC_DIGIT || c == BC_DOT) n = M_NSTR;
      end
      M_STR: begin
        if (c == BC_CHAR || c == BC_DIGIT || c == TK_DASH) n = M_STR;
      end
      M_NL: begin
        if (c == BC_NL) n = M_NL;
      end
      default: n = M_IDLE;
    endcase
    return n;
  endfunction

  // Fit an internal run length to the 16-bit output field.
  function automatic logic [15:0] length_out(logic [LENGTH_BITS-1:0] x);
    logic [63:0] w;
    w = 64'(x);
    return w[15:0];
  endfunction

  // Fit an internal offset to the 32-bit output field.
  function automatic logic [31:0] offset_out(logic [OFFSET_BITS-1:0] x);
    logic [63:0] w;
    w = 64'(x);
    return w[31:0];
  endfunction

endpackage

[hw/rtl/ptt_lexer.sv]
// Lexer state and per-byte token decision for the partition text tokenizer.
// Depends on ptt_pkg for codes, the class table and the result types.
`timescale 1ns / 1ps

module ptt_lexer (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [7:0]           data_byte,
  input  logic                 end_of_stream,
  output ptt_pkg::token_pair_t results
);

  logic [2:0]                      lexer_mode, lexer_mode_next;
  logic [ptt_pkg::LENGTH_BITS-1:0] pending_length, pending_length_next;
  logic [ptt_pkg::OFFSET_BITS-1:0] pending_offset, pending_offset_next;
  logic [ptt_pkg::OFFSET_BITS-1:0] stream_position, stream_position_next;

  logic [3:0]      cls;
  logic [2:0]      cont;
  logic            run_pending;
  ptt_pkg::token_t run_tok;
  ptt_pkg::token_t single_tok;
  logic            emit_single;

  // Class the byte and see whether it extends the pending run.
  always_comb begin
    cls         = ptt_pkg::byte_class(data_byte);
    cont        = ptt_pkg::continue_mode(lexer_mode, cls);
    run_pending = (lexer_mode != ptt_pkg::M_IDLE);

    run_tok.token_class  = ptt_pkg::mode_token(lexer_mode);
    run_tok.token_length = ptt_pkg::length_out(pending_length);
    run_tok.token_offset = ptt_pkg::offset_out(pending_offset);
    run_tok.last_result  = 1'b0;
  end

  // Next state and the results of this item.
  always_comb begin
    lexer_mode_next      = lexer_mode;
    pending_length_next  = pending_length;
    pending_offset_next  = pending_offset;
    stream_position_next = stream_position + ptt_pkg::OFFSET_BITS'(1);
    results              = '0;

    single_tok.token_class  = ptt_pkg::TK_UNK;
    single_tok.token_length = 16'd1;
    single_tok.token_offset = ptt_pkg::offset_out(stream_position);
    single_tok.last_result  = 1'b0;
    emit_single             = 1'b0;

    if (end_of_stream) begin
      // Flush the pending run, then the end-of-stream token; rearm.
      lexer_mode_next      = ptt_pkg::M_IDLE;
      pending_length_next  = '0;
      pending_offset_next  = '0;
      stream_position_next = '0;
      if (run_pending) begin
        results.count = 2'd2;
        results.first = run_tok;
        results.second.token_class  = ptt_pkg::TK_EOF;
        results.second.token_length = 16'd0;
        results.second.token_offset = ptt_pkg::offset_out(stream_position);
        results.second.last_result  = 1'b1;
      end else begin
        results.count = 2'd1;
        results.first.token_class  = ptt_pkg::TK_EOF;
        results.first.token_length = 16'd0;
        results.first.token_offset = ptt_pkg::offset_out(stream_position);
        results.first.last_result  = 1'b1;
      end
    end else if (run_pending && cont != ptt_pkg::M_IDLE) begin
      // The byte extends the run; the length saturates.
      lexer_mode_next = cont;
      if (pending_length != '1) begin
        pending_length_next = pending_length + ptt_pkg::LENGTH_BITS'(1);
      end
    end else begin
      // The run ends here; this byte opens a run or is a token by itself.
      lexer_mode_next     = ptt_pkg::M_IDLE;
      pending_length_next = ptt_pkg::LENGTH_BITS'(1);
      pending_offset_next = stream_position;
      single_tok.token_class = cls;
      unique case (cls)
        ptt_pkg::BC_SPACE: lexer_mode_next = ptt_pkg::M_WS;
        ptt_pkg::BC_NL:    lexer_mode_next = ptt_pkg::M_NL;
        ptt_pkg::BC_DIGIT: lexer_mode_next = ptt_pkg::M_INT;
        ptt_pkg::BC_CHAR:  lexer_mode_next = ptt_pkg::M_STR;
        ptt_pkg::BC_DOT, ptt_pkg::BC_UNK: begin
          emit_single            = 1'b1;
          single_tok.token_class = ptt_pkg::TK_UNK;
        end
        default: emit_single = 1'b1;
      endcase
      if (emit_single) begin
        pending_length_next = '0;
        pending_offset_next = '0;
      end

      single_tok.last_result = 1'b1;
      if (run_pending && emit_single) begin
        results.count  = 2'd2;
        results.first  = run_tok;
        results.second = single_tok;
      end else if (run_pending) begin
        results.count             = 2'd1;
        results.first             = run_tok;
        results.first.last_result = 1'b1;
      end else if (emit_single) begin
        results.count = 2'd1;
        results.first = single_tok;
      end
    end
  end

  // State registers advance only on an accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      lexer_mode      <= ptt_pkg::M_IDLE;
      pending_length  <= '0;
      pending_offset  <= '0;
      stream_position <= '0;
    end else if (accept) begin
      lexer_mode      <= lexer_mode_next;
      pending_length  <= pending_length_next;
      pending_offset  <= pending_offset_next;
      stream_position <= stream_position_next;
    end
  end

endmodule

[hw/rtl/ptt_out_fifo.sv]
// Small result queue that takes up to two items per cycle and gives one.
// Depends on ptt_pkg for the result types and the queue depth.
`timescale 1ns / 1ps

module ptt_out_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  ptt_pkg::token_pair_t results,
  input  logic                 pop,
  output logic                 not_empty,
  output logic                 almost_full,
  output ptt_pkg::token_t      head
);

  ptt_pkg::token_t entries [ptt_pkg::FIFO_DEPTH];

  logic [ptt_pkg::FIFO_AW-1:0] wr_ptr, wr_ptr_next;
  logic [ptt_pkg::FIFO_AW-1:0] rd_ptr, rd_ptr_next;
  logic [ptt_pkg::FIFO_AW:0]   count, count_next;
  logic [1:0]                  n_in;
  logic                        n_out;

  assign not_empty   = (count != '0);
  // Room for two is kept whenever input is taken.
  assign almost_full = (count > (ptt_pkg::FIFO_AW + 1)'(ptt_pkg::FIFO_DEPTH - 2));
  assign head        = entries[rd_ptr];

  // Pointer and fill bookkeeping.
  always_comb begin
    n_in        = push ? results.count : 2'd0;
    n_out       = pop && not_empty;
    wr_ptr_next = wr_ptr + ptt_pkg::FIFO_AW'(n_in);
    rd_ptr_next = rd_ptr + ptt_pkg::FIFO_AW'(n_out);
    count_next  = count + (ptt_pkg::FIFO_AW + 1)'(n_in)
                        - (ptt_pkg::FIFO_AW + 1)'(n_out);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  // Entry storage; the second result goes one place after the first.
  always_ff @(posedge clk) begin
    if (n_in != 2'd0) begin
      entries[wr_ptr] <= results.first;
    end
    if (n_in == 2'd2) begin
      entries[wr_ptr + ptt_pkg::FIFO_AW'(1)] <= results.second;
    end
  end

endmodule

[hw/rtl/partition_text_tokenizer_top.sv]
// Top level of the partition text tokenizer: lexer plus result queue.
// Depends on ptt_pkg, ptt_lexer and ptt_out_fifo.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------------
//   in      | input     | in_valid / in_stall  | data_byte, end_of_stream
//   out     | output    | out_valid / out_stall| token_class, token_length,
//           |           |                      | token_offset, last_result
//
// An input item is decided in the cycle it is accepted: one item per cycle while in_stall is low.
// Each item yields zero, one or two result items into a four-entry queue;
// the results are written into the queue registers as the item is accepted.
// in_stall rises when the queue holds more than two items, so the sustained
// rate is one item per cycle while results drain at one per cycle.
// Synchronous reset clears the lexer state and empties the queue.
`timescale 1ns / 1ps

module partition_text_tokenizer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        end_of_stream,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  token_class,
  output logic [15:0] token_length,
  output logic [31:0] token_offset,
  output logic        last_result
);

  ptt_pkg::token_pair_t results;
  ptt_pkg::token_t      head;
  logic                 accept;
  logic                 almost_full;

  assign in_stall = almost_full;
  assign accept   = in_valid && !almost_full;

  ptt_lexer u_lexer (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .data_byte     (data_byte),
    .end_of_stream (end_of_stream),
    .results       (results)
  );

  ptt_out_fifo u_fifo (
    .clk         (clk),
    .rst         (rst),
    .push        (accept),
    .results     (results),
    .pop         (!out_stall),
    .not_empty   (out_valid),
    .almost_full (almost_full),
    .head        (head)
  );

  // Result fields straight from the queue head.
  assign token_class  = head.token_class;
  assign token_length = head.token_length;
  assign token_offset = head.token_offset;
  assign last_result  = head.last_result;

endmodule
